// File: rtl/c8i_pkg.sv
// Shared types, constants and font table for the CHIP-8 interpreter core.
package c8i_pkg;

    localparam int MEM_AW     = 12;
    localparam int MEM_BYTES  = 4096;
    localparam int PC_W       = 13;
    localparam int SCR_W      = 64;
    localparam int SCR_H      = 32;
    localparam int SCR_YW     = 5;

    localparam logic [11:0] FONT_BASE   = 12'h050;
    localparam logic [11:0] FONT_END    = 12'h0A0;
    localparam logic [11:0] START_RESET = 12'h200;
    localparam logic [31:0] RAND_SEED   = 32'h0000ACE1;
    localparam logic [12:0] PC_LAST     = 13'd4095;

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_EXEC = 3'd1;
    localparam logic [2:0] OP_TICK = 3'd2;
    localparam logic [2:0] OP_ROW  = 3'd3;
    localparam logic [2:0] OP_BOX  = 3'd4;

    localparam logic [7:0] FONT [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_DISPATCH, ST_FETCH_CHK, ST_FETCH_HI, ST_FETCH_LO,
        ST_READ_X, ST_READ_Y, ST_READ_V0, ST_EXEC, ST_BCD, ST_STORE_RD,
        ST_STORE_WR, ST_LOAD_RD, ST_LOAD_WR, ST_DRAW_RD, ST_DRAW_WR,
        ST_DRAW_END, ST_FINISH
    } c8i_state_t;

    typedef enum logic [2:0] {
        KIND_NONE, KIND_BCD, KIND_STORE, KIND_LOAD, KIND_DRAW
    } c8i_kind_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [11:0] address;
        logic [7:0]  data;
        logic [15:0] keys;
        logic [4:0]  row;
    } c8i_in_t;

    typedef struct packed {
        logic [63:0] row_pixels;
        logic [12:0] program_counter;
        logic        waiting_for_key;
        logic [7:0]  delay_value;
        logic        dirty;
        logic [6:0]  dirty_x_min;
        logic [5:0]  dirty_y_min;
        logic [5:0]  dirty_x_max;
        logic [4:0]  dirty_y_max;
    } c8i_out_t;

    typedef struct packed {
        c8i_state_t step;
        logic       accept;
        logic       load_out;
    } c8i_cmd_t;

    typedef struct packed {
        logic       init_done;
        logic [2:0] op;
        c8i_kind_t  kind;
        logic       bcd_last;
        logic       loop_last;
        logic       draw_done;
    } c8i_status_t;

    function automatic logic [7:0] font_byte(input logic [11:0] a);
        logic [11:0] off;
        off = a - FONT_BASE;
        if (a >= FONT_BASE && a < FONT_END) begin
            return FONT[off[6:0]];
        end
        return 8'h00;
    endfunction

endpackage

// File: rtl/c8i_datapath.sv
// Datapath: memories, registers, instruction execution and result register.
module c8i_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [11:0]          cfg_wr_data,
    input  c8i_pkg::c8i_in_t     s_data,
    input  c8i_pkg::c8i_cmd_t    cmd,
    output c8i_pkg::c8i_status_t st,
    output c8i_pkg::c8i_out_t    m_data
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int IX_W = $clog2(STACK_DEPTH);

    // storage
    logic [7:0]  mem [c8i_pkg::MEM_BYTES];
    logic [63:0] fb_mem [c8i_pkg::SCR_H];
    logic [12:0] stack_mem [STACK_DEPTH];
    logic [7:0]  v_reg [16];

    logic [7:0]  mem_rdata_reg;
    logic [63:0] fb_rdata_reg;
    logic        fbv_rd_reg;
    logic [7:0]  v_rdata_reg;

    logic [11:0] mem_raddr, mem_waddr;
    logic        mem_we;
    logic [7:0]  mem_wdata;
    logic [4:0]  fb_raddr, fb_waddr;
    logic        fb_we;
    logic [63:0] fb_wdata;
    logic [3:0]  v_raddr, v_waddr;
    logic        v_we, vf_we;
    logic [7:0]  v_wdata, vf_wdata;
    logic        stk_we;

    c8i_pkg::c8i_in_t  in_reg, in_next;
    c8i_pkg::c8i_out_t out_reg, out_next;
    logic [15:0] ir_reg, ir_next;
    logic [7:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        coll_reg, coll_next, skip_reg, skip_next, oob_reg, oob_next;
    logic [4:0]  drow_reg, drow_next;
    logic [11:0] init_reg, init_next, start_reg, start_next;
    logic [12:0] pc_reg, pc_next;
    logic [15:0] idx_reg, idx_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [7:0]  delay_reg, delay_next;
    logic [31:0] rand_reg, rand_next;
    logic [6:0]  bxmin_reg, bxmin_next;
    logic [5:0]  bymin_reg, bymin_next;
    logic [5:0]  bxmax_reg, bxmax_next;
    logic [4:0]  bymax_reg, bymax_next;
    logic        changed_reg, changed_next, wait_reg, wait_next;
    logic [31:0] fbv_reg, fbv_next;

    // instruction fields
    logic [3:0]  nib, op_x, op_y, op_n;
    logic [7:0]  kk;
    logic [11:0] nnn;
    assign nib  = ir_reg[15:12];
    assign op_x = ir_reg[11:8];
    assign op_y = ir_reg[7:4];
    assign op_n = ir_reg[3:0];
    assign kk   = ir_reg[7:0];
    assign nnn  = ir_reg[11:0];

    logic [12:0] pc_p2;
    logic [SP_W-1:0] sp_m1;
    logic [12:0] stack_top;
    assign pc_p2     = pc_reg + 13'd2;
    assign sp_m1     = sp_reg - 1'b1;
    assign stack_top = stack_mem[sp_m1[IX_W-1:0]];

    // BCD digits of Vx
    logic [1:0]  bcd_h;
    logic [7:0]  bcd_r;
    logic [14:0] bcd_p;
    logic [3:0]  bcd_t;
    logic [7:0]  bcd_o;
    always_comb begin
        if (vx_reg >= 8'd200) begin
            bcd_h = 2'd2;
            bcd_r = vx_reg - 8'd200;
        end else if (vx_reg >= 8'd100) begin
            bcd_h = 2'd1;
            bcd_r = vx_reg - 8'd100;
        end else begin
            bcd_h = 2'd0;
            bcd_r = vx_reg;
        end
        bcd_p = 15'(bcd_r[6:0]) * 15'd205;
        bcd_t = bcd_p[14:11];
        bcd_o = bcd_r - 8'(bcd_t) * 8'd10;
    end

    // xorshift32
    logic [31:0] rs1, rs2, rs3;
    assign rs1 = rand_reg ^ (rand_reg << 13);
    assign rs2 = rs1 ^ (rs1 >> 17);
    assign rs3 = rs2 ^ (rs2 << 5);

    // lowest held key
    logic [3:0] key_lo;
    always_comb begin
        key_lo = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (in_reg.keys[k]) key_lo = 4'(k);
        end
    end

    // sprite row
    logic [5:0]  xp;
    logic [6:0]  avail;
    logic [7:0]  clip_m, sbits, clipped;
    logic [63:0] spr_mask, fb_old;
    logic [2:0]  lead, trail;
    logic [6:0]  cand_min;
    logic [5:0]  cand_max;
    logic [5:0]  draw_row;
    logic [16:0] draw_at;
    assign xp       = vx_reg[5:0];
    assign avail    = 7'd64 - {1'b0, xp};
    assign clip_m   = (avail >= 7'd8) ? 8'hFF : ~(8'hFF >> avail[2:0]);
    assign sbits    = oob_reg ? 8'h00 : mem_rdata_reg;
    assign clipped  = sbits & clip_m;
    assign spr_mask = {clipped, 56'd0} >> xp;
    assign fb_old   = fbv_rd_reg ? fb_rdata_reg : 64'd0;
    assign cand_min = {1'b0, xp} + {4'd0, lead};
    assign cand_max = xp + {3'd0, trail};
    assign draw_row = {1'b0, vy_reg[4:0]} + {2'b0, cnt_reg};
    assign draw_at  = {1'b0, idx_reg} + {13'd0, cnt_reg};
    always_comb begin
        lead  = 3'd0;
        trail = 3'd0;
        for (int c = 0; c < 8; c++) begin
            if (clipped[7-c]) trail = 3'(c);
        end
        for (int c = 7; c >= 0; c--) begin
            if (clipped[7-c]) lead = 3'(c);
        end
    end

    logic [16:0] idx_p2, idx_px;
    assign idx_p2 = {1'b0, idx_reg} + 17'd2;
    assign idx_px = {1'b0, idx_reg} + {13'd0, op_x};

    // status
    always_comb begin
        st.init_done = (init_reg == 12'hFFF);
        st.op        = in_reg.operation;
        st.bcd_last  = (cnt_reg == 4'd2);
        st.loop_last = (cnt_reg == op_x);
        st.draw_done = (cnt_reg == op_n);
        st.kind      = c8i_pkg::KIND_NONE;
        if (nib == 4'hD) begin
            st.kind = c8i_pkg::KIND_DRAW;
        end else if (nib == 4'hF) begin
            if (kk == 8'h33 && idx_p2 < 17'(c8i_pkg::MEM_BYTES)) begin
                st.kind = c8i_pkg::KIND_BCD;
            end else if (kk == 8'h55 && idx_px < 17'(c8i_pkg::MEM_BYTES)) begin
                st.kind = c8i_pkg::KIND_STORE;
            end else if (kk == 8'h65 && idx_px < 17'(c8i_pkg::MEM_BYTES)) begin
                st.kind = c8i_pkg::KIND_LOAD;
            end
        end
    end

    always_comb begin
        logic [8:0] sum9;
        logic [7:0] vx_f, vy_f;
        sum9 = {1'b0, vx_reg} + {1'b0, vy_reg};
        vx_f = vx_reg;
        vy_f = vy_reg;

        in_next = in_reg;  out_next = out_reg;  ir_next = ir_reg;
        vx_next = vx_reg;  vy_next = vy_reg;    cnt_next = cnt_reg;
        coll_next = coll_reg;  skip_next = skip_reg;  oob_next = oob_reg;
        drow_next = drow_reg;  init_next = init_reg;
        start_next = cfg_wr_en ? cfg_wr_data : start_reg;
        pc_next = pc_reg;  idx_next = idx_reg;  sp_next = sp_reg;
        delay_next = delay_reg;  rand_next = rand_reg;
        bxmin_next = bxmin_reg;  bymin_next = bymin_reg;
        bxmax_next = bxmax_reg;  bymax_next = bymax_reg;
        changed_next = changed_reg;  wait_next = wait_reg;  fbv_next = fbv_reg;

        mem_raddr = 12'd0;  mem_waddr = 12'd0;  mem_we = 1'b0;  mem_wdata = 8'd0;
        fb_raddr = 5'd0;  fb_waddr = 5'd0;  fb_we = 1'b0;  fb_wdata = 64'd0;
        v_raddr = 4'd0;  v_waddr = 4'd0;  v_we = 1'b0;  v_wdata = 8'd0;
        vf_we = 1'b0;  vf_wdata = 8'd0;  stk_we = 1'b0;

        unique case (cmd.step)
            c8i_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = init_reg;
                mem_wdata = c8i_pkg::font_byte(init_reg);
                init_next = init_reg + 12'd1;
            end
            c8i_pkg::ST_IDLE: begin
                if (cmd.accept) begin
                    in_next   = s_data;
                    wait_next = 1'b0;
                end
            end
            c8i_pkg::ST_DISPATCH: begin
                unique case (in_reg.operation)
                    c8i_pkg::OP_LOAD: begin
                        mem_we    = 1'b1;
                        mem_waddr = in_reg.address;
                        mem_wdata = in_reg.data;
                    end
                    c8i_pkg::OP_TICK: begin
                        if (delay_reg != 8'd0) delay_next = delay_reg - 8'd1;
                    end
                    c8i_pkg::OP_ROW: fb_raddr = in_reg.row;
                    default: ;
                endcase
            end
            c8i_pkg::ST_FETCH_CHK: begin
                if (pc_reg >= c8i_pkg::PC_LAST) pc_next = {1'b0, start_reg};
            end
            c8i_pkg::ST_FETCH_HI: mem_raddr = pc_reg[11:0];
            c8i_pkg::ST_FETCH_LO: begin
                ir_next[15:8] = mem_rdata_reg;
                mem_raddr     = pc_reg[11:0] + 12'd1;
            end
            c8i_pkg::ST_READ_X: begin
                ir_next[7:0] = mem_rdata_reg;
                pc_next      = pc_p2;
                v_raddr      = op_x;
            end
            c8i_pkg::ST_READ_Y: begin
                vx_next = v_rdata_reg;
                v_raddr = op_y;
            end
            c8i_pkg::ST_READ_V0: begin
                vy_next = v_rdata_reg;
                v_raddr = 4'd0;
            end
            c8i_pkg::ST_EXEC: begin
                cnt_next  = 4'd0;
                coll_next = 1'b0;
                v_waddr   = op_x;
                unique case (nib)
                    4'h0: begin
                        if (op_n == 4'h0) begin
                            fbv_next     = 32'd0;
                            bxmin_next   = 7'd0;
                            bymin_next   = 6'd0;
                            bxmax_next   = 6'd63;
                            bymax_next   = 5'd31;
                            changed_next = 1'b1;
                        end else if (op_n == 4'hE && sp_reg != '0) begin
                            sp_next = sp_m1;
                            pc_next = stack_top;
                        end
                    end
                    4'h1: pc_next = {1'b0, nnn};
                    4'h2: begin
                        if (sp_reg < SP_W'(STACK_DEPTH)) begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + 1'b1;
                        end
                        pc_next = {1'b0, nnn};
                    end
                    4'h3: if (vx_reg == kk) pc_next = pc_p2;
                    4'h4: if (vx_reg != kk) pc_next = pc_p2;
                    4'h5: if (vx_reg == vy_reg) pc_next = pc_p2;
                    4'h6: begin
                        v_we = 1'b1;  v_wdata = kk;
                    end
                    4'h7: begin
                        v_we = 1'b1;  v_wdata = vx_reg + kk;
                    end
                    4'h8: begin
                        v_we = 1'b1;
                        // VF is set first, so in 8xy5, 8xy6, 8xy7 and 8xyE a VF operand sees the new flag
                        unique case (op_n)
                            4'h0: v_wdata = vy_reg;
                            4'h1: v_wdata = vx_reg | vy_reg;
                            4'h2: v_wdata = vx_reg & vy_reg;
                            4'h3: v_wdata = vx_reg ^ vy_reg;
                            4'h4: begin
                                vf_we = 1'b1;  vf_wdata = {7'd0, sum9[8]};
                                v_wdata = sum9[7:0];
                            end
                            4'h5: begin
                                vf_we = 1'b1;  vf_wdata = {7'd0, vx_reg > vy_reg};
                                if (op_x == 4'hF) vx_f = vf_wdata;
                                if (op_y == 4'hF) vy_f = vf_wdata;
                                v_wdata = vx_f - vy_f;
                            end
                            4'h6: begin
                                vf_we = 1'b1;  vf_wdata = {7'd0, vx_reg[0]};
                                if (op_x == 4'hF) vx_f = vf_wdata;
                                v_wdata = vx_f >> 1;
                            end
                            4'h7: begin
                                vf_we = 1'b1;  vf_wdata = {7'd0, vy_reg > vx_reg};
                                if (op_x == 4'hF) vx_f = vf_wdata;
                                if (op_y == 4'hF) vy_f = vf_wdata;
                                v_wdata = vy_f - vx_f;
                            end
                            4'hE: begin
                                vf_we = 1'b1;  vf_wdata = {7'd0, vx_reg[7]};
                                if (op_x == 4'hF) vx_f = vf_wdata;
                                v_wdata = vx_f << 1;
                            end
                            default: v_we = 1'b0;
                        endcase
                    end
                    4'h9: if (vx_reg != vy_reg) pc_next = pc_p2;
                    4'hA: idx_next = {4'd0, nnn};
                    // v_rdata holds V0 here
                    4'hB: pc_next = {5'd0, v_rdata_reg} + {1'b0, nnn};
                    4'hC: begin
                        rand_next = rs3;
                        v_we      = 1'b1;
                        v_wdata   = rs3[7:0] & kk;
                    end
                    4'hD: ;
                    4'hE: begin
                        if (op_n == 4'hE) begin
                            if (vx_reg < 8'd16 && in_reg.keys[vx_reg[3:0]]) pc_next = pc_p2;
                        end else if (op_n == 4'h1) begin
                            if (vx_reg < 8'd16 && !in_reg.keys[vx_reg[3:0]]) pc_next = pc_p2;
                        end
                    end
                    default: begin
                        priority case (kk)
                            8'h07: begin
                                v_we = 1'b1;  v_wdata = delay_reg;
                            end
                            8'h0A: begin
                                if (in_reg.keys != 16'd0) begin
                                    v_we = 1'b1;  v_wdata = {4'd0, key_lo};
                                end else begin
                                    pc_next   = pc_reg - 13'd2;
                                    wait_next = 1'b1;
                                end
                            end
                            8'h15: delay_next = vx_reg;
                            8'h1E: idx_next = idx_reg + {8'd0, vx_reg};
                            8'h29: idx_next = 16'(c8i_pkg::FONT_BASE)
                                            + {6'd0, vx_reg, 2'b00} + {8'd0, vx_reg};
                            default: ;
                        endcase
                    end
                endcase
            end
            c8i_pkg::ST_BCD: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[11:0] + {8'd0, cnt_reg};
                unique case (cnt_reg[1:0])
                    2'd0:    mem_wdata = {6'd0, bcd_h};
                    2'd1:    mem_wdata = {4'd0, bcd_t};
                    default: mem_wdata = bcd_o;
                endcase
                cnt_next = cnt_reg + 4'd1;
            end
            c8i_pkg::ST_STORE_RD: v_raddr = cnt_reg;
            c8i_pkg::ST_STORE_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[11:0] + {8'd0, cnt_reg};
                mem_wdata = v_rdata_reg;
                cnt_next  = cnt_reg + 4'd1;
            end
            c8i_pkg::ST_LOAD_RD: mem_raddr = idx_reg[11:0] + {8'd0, cnt_reg};
            c8i_pkg::ST_LOAD_WR: begin
                v_we     = 1'b1;
                v_waddr  = cnt_reg;
                v_wdata  = mem_rdata_reg;
                cnt_next = cnt_reg + 4'd1;
            end
            c8i_pkg::ST_DRAW_RD: begin
                mem_raddr = draw_at[11:0];
                fb_raddr  = draw_row[4:0];
                drow_next = draw_row[4:0];
                skip_next = draw_row[5];
                oob_next  = (draw_at >= 17'(c8i_pkg::MEM_BYTES));
            end
            c8i_pkg::ST_DRAW_WR: begin
                cnt_next = cnt_reg + 4'd1;
                if (!skip_reg) begin
                    fb_we    = 1'b1;
                    fb_waddr = drow_reg;
                    fb_wdata = fb_old ^ spr_mask;
                    fbv_next[drow_reg] = 1'b1;
                    if ((fb_old & spr_mask) != 64'd0) coll_next = 1'b1;
                    if (clipped != 8'd0) begin
                        changed_next = 1'b1;
                        if (cand_min < bxmin_reg) bxmin_next = cand_min;
                        if (cand_max > bxmax_reg) bxmax_next = cand_max;
                        if ({1'b0, drow_reg} < bymin_reg) bymin_next = {1'b0, drow_reg};
                        if (drow_reg > bymax_reg) bymax_next = drow_reg;
                    end
                end
            end
            c8i_pkg::ST_DRAW_END: begin
                vf_we    = 1'b1;
                vf_wdata = {7'd0, coll_reg};
            end
            c8i_pkg::ST_FINISH: begin
                // keep the selected row on the read port while the result waits
                fb_raddr = in_reg.row;
                if (cmd.load_out) begin
                    out_next.row_pixels      = (in_reg.operation == c8i_pkg::OP_ROW)
                                               ? fb_old : 64'd0;
                    out_next.program_counter = pc_reg;
                    out_next.waiting_for_key = wait_reg;
                    out_next.delay_value     = delay_reg;
                    out_next.dirty           = changed_reg;
                    out_next.dirty_x_min     = bxmin_reg;
                    out_next.dirty_y_min     = bymin_reg;
                    out_next.dirty_x_max     = bxmax_reg;
                    out_next.dirty_y_max     = bymax_reg;
                    if (in_reg.operation == c8i_pkg::OP_BOX) begin
                        bxmin_next   = 7'd64;
                        bymin_next   = 6'd32;
                        bxmax_next   = 6'd0;
                        bymax_next   = 5'd0;
                        changed_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
        fb_rdata_reg <= fb_mem[fb_raddr];
        fbv_rd_reg   <= fbv_reg[fb_raddr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) stack_mem[sp_reg[IX_W-1:0]] <= pc_reg;
    end

    // register file; VF goes first so Vx wins when x is F
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) v_reg[i] <= 8'd0;
        end else begin
            if (vf_we) v_reg[15] <= vf_wdata;
            if (v_we) v_reg[v_waddr] <= v_wdata;
        end
        v_rdata_reg <= v_reg[v_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg    <= 12'd0;
            start_reg   <= c8i_pkg::START_RESET;
            pc_reg      <= {1'b0, c8i_pkg::START_RESET};
            idx_reg     <= 16'd0;
            sp_reg      <= '0;
            delay_reg   <= 8'd0;
            rand_reg    <= c8i_pkg::RAND_SEED;
            bxmin_reg   <= 7'd64;
            bymin_reg   <= 6'd32;
            bxmax_reg   <= 6'd0;
            bymax_reg   <= 5'd0;
            changed_reg <= 1'b0;
            wait_reg    <= 1'b0;
            fbv_reg     <= 32'd0;
        end else begin
            init_reg    <= init_next;
            start_reg   <= start_next;
            pc_reg      <= pc_next;
            idx_reg     <= idx_next;
            sp_reg      <= sp_next;
            delay_reg   <= delay_next;
            rand_reg    <= rand_next;
            bxmin_reg   <= bxmin_next;
            bymin_reg   <= bymin_next;
            bxmax_reg   <= bxmax_next;
            bymax_reg   <= bymax_next;
            changed_reg <= changed_next;
            wait_reg    <= wait_next;
            fbv_reg     <= fbv_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg   <= in_next;
        out_reg  <= out_next;
        ir_reg   <= ir_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        cnt_reg  <= cnt_next;
        coll_reg <= coll_next;
        skip_reg <= skip_next;
        oob_reg  <= oob_next;
        drow_reg <= drow_next;
    end

    assign m_data = out_reg;

endmodule

// File: rtl/c8i_control.sv
// Controller: sequencing state machine and channel handshakes.
module c8i_control (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  c8i_pkg::c8i_status_t st,
    output c8i_pkg::c8i_cmd_t    cmd
);

    c8i_pkg::c8i_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= c8i_pkg::ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd.step     = state_reg;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            c8i_pkg::ST_INIT: if (st.init_done) state_next = c8i_pkg::ST_IDLE;
            c8i_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = c8i_pkg::ST_DISPATCH;
                end
            end
            c8i_pkg::ST_DISPATCH: begin
                state_next = (st.op == c8i_pkg::OP_EXEC) ? c8i_pkg::ST_FETCH_CHK
                                                         : c8i_pkg::ST_FINISH;
            end
            c8i_pkg::ST_FETCH_CHK: state_next = c8i_pkg::ST_FETCH_HI;
            c8i_pkg::ST_FETCH_HI:  state_next = c8i_pkg::ST_FETCH_LO;
            c8i_pkg::ST_FETCH_LO:  state_next = c8i_pkg::ST_READ_X;
            c8i_pkg::ST_READ_X:    state_next = c8i_pkg::ST_READ_Y;
            c8i_pkg::ST_READ_Y:    state_next = c8i_pkg::ST_READ_V0;
            c8i_pkg::ST_READ_V0:   state_next = c8i_pkg::ST_EXEC;
            c8i_pkg::ST_EXEC: begin
                unique case (st.kind)
                    c8i_pkg::KIND_BCD:   state_next = c8i_pkg::ST_BCD;
                    c8i_pkg::KIND_STORE: state_next = c8i_pkg::ST_STORE_RD;
                    c8i_pkg::KIND_LOAD:  state_next = c8i_pkg::ST_LOAD_RD;
                    c8i_pkg::KIND_DRAW:  state_next = c8i_pkg::ST_DRAW_RD;
                    default:             state_next = c8i_pkg::ST_FINISH;
                endcase
            end
            c8i_pkg::ST_BCD: if (st.bcd_last) state_next = c8i_pkg::ST_FINISH;
            c8i_pkg::ST_STORE_RD: state_next = c8i_pkg::ST_STORE_WR;
            c8i_pkg::ST_STORE_WR: begin
                state_next = st.loop_last ? c8i_pkg::ST_FINISH : c8i_pkg::ST_STORE_RD;
            end
            c8i_pkg::ST_LOAD_RD: state_next = c8i_pkg::ST_LOAD_WR;
            c8i_pkg::ST_LOAD_WR: begin
                state_next = st.loop_last ? c8i_pkg::ST_FINISH : c8i_pkg::ST_LOAD_RD;
            end
            c8i_pkg::ST_DRAW_RD: begin
                state_next = st.draw_done ? c8i_pkg::ST_DRAW_END : c8i_pkg::ST_DRAW_WR;
            end
            c8i_pkg::ST_DRAW_WR:  state_next = c8i_pkg::ST_DRAW_RD;
            c8i_pkg::ST_DRAW_END: state_next = c8i_pkg::ST_FINISH;
            c8i_pkg::ST_FINISH: begin
                // result register free or being emptied this cycle
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = c8i_pkg::ST_IDLE;
                end
            end
            default: state_next = c8i_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/chip8_interpreter_core.sv
// Top level of the CHIP-8 interpreter core.
//
//  channel  direction  handshake              payload
//  s_       in         s_valid / s_ready      s_data  (c8i_in_t)
//  m_       out        m_valid / m_ready      m_data  (c8i_out_t)
//  cfg_     in         cfg_wr_en              cfg_wr_data (start address)
//
// One operation at a time. Load, tick, row read and box pass through dispatch
// and finish; an instruction also fetches, reads Vx, Vy and V0 and executes,
// then Fx33 writes its digits, Fx55/Fx65 take a read and a write step per
// register, and Dxyn a read and a write step per sprite row plus a flag step.
// After reset a clearing pass loads memory and the font; s_ready stays low until
// it ends. A result held by m_ready low blocks the next operation only at its final step.
module chip8_interpreter_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [11:0]       cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  c8i_pkg::c8i_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output c8i_pkg::c8i_out_t m_data
);

    c8i_pkg::c8i_status_t st;
    c8i_pkg::c8i_cmd_t    cmd;

    c8i_control u_control (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    c8i_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .st          (st),
        .m_data      (m_data)
    );

endmodule
